/* rtl/rsq_pkg.sv */
package rsq_pkg;

  localparam logic [31:0] RSQ_MAGIC    = 32'h5f3759df;
  localparam logic [31:0] FP_HALF      = 32'h3f000000;
  localparam logic [31:0] FP_ONE_HALF  = 32'h3fc00000;
  localparam logic [31:0] FP_QNAN      = 32'hffc00000;
  localparam logic [31:0] FP_QUIET_BIT = 32'h00400000;
  localparam logic [7:0]  EXP_MAX      = 8'hff;

  typedef struct packed {
    logic        is_nan;
    logic        is_inf;
    logic        is_zero;
    logic [8:0]  exp_eff;
    logic [23:0] mant;
  } fp_unpk_t;

  function automatic fp_unpk_t fp_unpack(input logic [31:0] f);
    fp_unpk_t u;
    u.is_nan  = (f[30:23] == EXP_MAX) && (f[22:0] != 23'd0);
    u.is_inf  = (f[30:23] == EXP_MAX) && (f[22:0] == 23'd0);
    u.is_zero = (f[30:0] == 31'd0);
    u.exp_eff = (f[30:23] == 8'd0) ? 9'd1 : {1'b0, f[30:23]};
    u.mant    = {(f[30:23] != 8'd0), f[22:0]};
    return u;
  endfunction

  function automatic logic [6:0] lzc64(input logic [63:0] x);
    logic [6:0] n;
    logic       hit;
    n   = 7'd64;
    hit = 1'b0;
    for (int i = 63; i >= 0; i--) begin
      if (!hit && x[i]) begin
        n   = 7'(63 - i);
        hit = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

/* rtl/fast_inverse_square_root_top.sv */
// Structure: five 3-stage float units lie between request accept and result.
// Throughput: one request per cycle; the whole pipeline holds while out_stall
//   is high with a result waiting, and in_stall follows that hold.
// Reset: synchronous active-low rst_n clears all stage valid bits; the
//   datapath registers are not reset.
module fast_inverse_square_root_top import rsq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_value_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_result_bits
);

  logic        en;
  logic [31:0] guess;
  logic        m1_vld, m2_vld, m3_vld, sb_vld;
  logic [31:0] half_v, y1, t_v, y2, u_v, y3, w_v, y4;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;
  assign guess    = RSQ_MAGIC - {in_value_bits[31], in_value_bits[31:1]};

  rsq_fmul u_half (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(in_valid),
    .a(in_value_bits), .b(FP_HALF), .side_in(guess),
    .out_vld(m1_vld), .p(half_v), .side_out(y1)
  );

  rsq_fmul u_hy (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(m1_vld),
    .a(half_v), .b(y1), .side_in(y1),
    .out_vld(m2_vld), .p(t_v), .side_out(y2)
  );

  rsq_fmul u_hyy (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(m2_vld),
    .a(t_v), .b(y2), .side_in(y2),
    .out_vld(m3_vld), .p(u_v), .side_out(y3)
  );

  rsq_fsub u_sub (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(m3_vld),
    .a(FP_ONE_HALF), .b(u_v), .side_in(y3),
    .out_vld(sb_vld), .d(w_v), .side_out(y4)
  );

  rsq_fmul u_fin (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(sb_vld),
    .a(y4), .b(w_v), .side_in(32'd0),
    .out_vld(out_valid), .p(out_result_bits), .side_out()
  );

`ifndef SYNTHESIS
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid && !sb_vld)
    else $error("pipeline valid not cleared by reset");
  a_hold_mid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(sb_vld) && $stable(w_v) && $stable(y4))
    else $error("pipeline advanced during hold");
  a_hold_in: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> in_stall)
    else $error("request taken during hold");
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_stall && m3_vld) |=> u_sub.a_vld_r)
    else $error("item lost between multiply and subtract");
`endif

endmodule

/* rtl/rsq_fmul.sv */
module rsq_fmul import rsq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_vld,
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic [31:0] side_in,
  output logic        out_vld,
  output logic [31:0] p,
  output logic [31:0] side_out
);

  fp_unpk_t ua, ub;
  logic        sgn;
  logic        spec;
  logic [31:0] spec_val;

  always_comb begin
    ua       = fp_unpack(a);
    ub       = fp_unpack(b);
    sgn      = a[31] ^ b[31];
    spec     = 1'b1;
    spec_val = 32'd0;
    if (ua.is_nan) begin
      spec_val = a | FP_QUIET_BIT;
    end else if (ub.is_nan) begin
      spec_val = b | FP_QUIET_BIT;
    end else if ((ua.is_inf && ub.is_zero) || (ub.is_inf && ua.is_zero)) begin
      spec_val = FP_QNAN;
    end else if (ua.is_inf || ub.is_inf) begin
      spec_val = {sgn, EXP_MAX, 23'd0};
    end else if (ua.is_zero || ub.is_zero) begin
      spec_val = {sgn, 31'd0};
    end else begin
      spec = 1'b0;
    end
  end

  // stage A: mantissa product
  logic        a_vld_r;
  logic [31:0] a_side_r, a_spv_r;
  logic        a_sgn_r, a_spec_r;
  logic [47:0] a_prod_r;
  logic [8:0]  a_esum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_side_r <= side_in;
      a_spv_r  <= spec_val;
      a_spec_r <= spec;
      a_sgn_r  <= sgn;
      a_prod_r <= ua.mant * ub.mant;
      a_esum_r <= ua.exp_eff + ub.exp_eff;
    end
  end

  // stage B: normalize left
  logic [6:0]         lz;
  logic [47:0]        norm;
  logic signed [10:0] be;

  always_comb begin
    lz   = lzc64({a_prod_r, 16'hffff});
    norm = a_prod_r << lz[5:0];
    be   = $signed({2'b00, a_esum_r}) - 11'sd126 - $signed({4'b0000, lz});
  end

  logic        b_vld_r;
  logic [31:0] b_side_r, b_spv_r;
  logic        b_sgn_r, b_spec_r;
  logic [47:0] b_n_r;
  logic signed [10:0] b_be_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (en) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_side_r <= a_side_r;
      b_spv_r  <= a_spv_r;
      b_spec_r <= a_spec_r;
      b_sgn_r  <= a_sgn_r;
      b_n_r    <= norm;
      b_be_r   <= be;
    end
  end

  // stage C: denormal shift, round, pack
  logic signed [10:0] sh_full;
  logic [5:0]  sh;
  logic [95:0] wide;
  logic [47:0] nsh;
  logic        lost, ovf, g, st, inc;
  logic [7:0]  field;
  logic [30:0] mag;
  logic [31:0] res;

  always_comb begin
    sh_full = 11'sd1 - b_be_r;
    sh      = (sh_full > 11'sd63) ? 6'd63 : sh_full[5:0];
    wide    = {b_n_r, 48'd0} >> sh;
    ovf     = 1'b0;
    if (b_be_r <= 11'sd0) begin
      nsh   = wide[95:48];
      lost  = |wide[47:0];
      field = 8'd0;
    end else begin
      nsh   = b_n_r;
      lost  = 1'b0;
      field = b_be_r[7:0];
      ovf   = (b_be_r >= 11'sd255);
    end
    g   = nsh[23];
    st  = (|nsh[22:0]) | lost;
    inc = g & (st | nsh[24]);
    mag = {field, nsh[46:24]} + {30'd0, inc};
    if (b_spec_r) begin
      res = b_spv_r;
    end else if (ovf) begin
      res = {b_sgn_r, EXP_MAX, 23'd0};
    end else begin
      res = {b_sgn_r, mag};
    end
  end

  logic        c_vld_r;
  logic [31:0] c_res_r, c_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (en) begin
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_res_r  <= res;
      c_side_r <= b_side_r;
    end
  end

  assign out_vld  = c_vld_r;
  assign p        = c_res_r;
  assign side_out = c_side_r;

endmodule

/* rtl/rsq_fsub.sv */
module rsq_fsub import rsq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_vld,
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic [31:0] side_in,
  output logic        out_vld,
  output logic [31:0] d,
  output logic [31:0] side_out
);

  fp_unpk_t ua, ub, ux, uy;
  logic        sa, sb, sx, sy, swap;
  logic        spec;
  logic [31:0] spec_val;
  logic [8:0]  dexp;
  logic [5:0]  dcl;
  logic [50:0] ysh;
  logic [26:0] yal;

  always_comb begin
    ua   = fp_unpack(a);
    ub   = fp_unpack(b);
    sa   = a[31];
    sb   = ~b[31];
    swap = (b[30:0] > a[30:0]);
    ux   = swap ? ub : ua;
    uy   = swap ? ua : ub;
    sx   = swap ? sb : sa;
    sy   = swap ? sa : sb;
    dexp = ux.exp_eff - uy.exp_eff;
    dcl  = (dexp > 9'd51) ? 6'd51 : dexp[5:0];
    ysh  = {uy.mant, 27'd0} >> dcl;
    yal  = {ysh[50:25], ysh[24] | (|ysh[23:0])};
    spec     = 1'b1;
    spec_val = 32'd0;
    if (ua.is_nan) begin
      spec_val = a | FP_QUIET_BIT;
    end else if (ub.is_nan) begin
      spec_val = b | FP_QUIET_BIT;
    end else if (ua.is_inf && ub.is_inf && (sa != sb)) begin
      spec_val = FP_QNAN;
    end else if (ua.is_inf) begin
      spec_val = a;
    end else if (ub.is_inf) begin
      spec_val = {sb, b[30:0]};
    end else begin
      spec = 1'b0;
    end
  end

  // stage A: swap and align
  logic        a_vld_r;
  logic [31:0] a_side_r, a_spv_r;
  logic        a_spec_r, a_sx_r, a_sub_r, a_zs_r;
  logic [7:0]  a_ex_r;
  logic [26:0] a_xal_r, a_yal_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_side_r <= side_in;
      a_spv_r  <= spec_val;
      a_spec_r <= spec;
      a_sx_r   <= sx;
      a_sub_r  <= (sx != sy);
      a_zs_r   <= sa & sb;
      a_ex_r   <= ux.exp_eff[7:0];
      a_xal_r  <= {ux.mant, 3'd0};
      a_yal_r  <= yal;
    end
  end

  // stage B: add and normalize
  logic [27:0] s28, n28;
  logic [6:0]  lz;
  logic [7:0]  lsh;
  logic [8:0]  e;

  always_comb begin
    s28 = a_sub_r ? ({1'b0, a_xal_r} - {1'b0, a_yal_r})
                  : ({1'b0, a_xal_r} + {1'b0, a_yal_r});
    lz  = lzc64({s28[26:0], 37'h1f_ffff_ffff});
    lsh = ({1'b0, lz} < (a_ex_r - 8'd1)) ? {1'b0, lz} : (a_ex_r - 8'd1);
    if (s28[27]) begin
      n28 = {1'b0, s28[27:2], s28[1] | s28[0]};
      e   = {1'b0, a_ex_r} + 9'd1;
    end else begin
      n28 = s28 << lsh[4:0];
      e   = {1'b0, a_ex_r} - {1'b0, lsh};
    end
  end

  logic        b_vld_r;
  logic [31:0] b_side_r, b_spv_r;
  logic        b_spec_r, b_sx_r, b_zero_r, b_zs_r;
  logic [26:0] b_n_r;
  logic [8:0]  b_e_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (en) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_side_r <= a_side_r;
      b_spv_r  <= a_spv_r;
      b_spec_r <= a_spec_r;
      b_sx_r   <= a_sx_r;
      b_zs_r   <= a_zs_r;
      b_zero_r <= (s28 == 28'd0);
      b_n_r    <= n28[26:0];
      b_e_r    <= e;
    end
  end

  // stage C: round and pack
  logic [7:0]  field;
  logic        g, st, inc, ovf;
  logic [30:0] mag;
  logic [31:0] res;

  always_comb begin
    field = b_n_r[26] ? b_e_r[7:0] : 8'd0;
    ovf   = b_n_r[26] && (b_e_r >= 9'd255);
    g     = b_n_r[2];
    st    = b_n_r[1] | b_n_r[0];
    inc   = g & (st | b_n_r[3]);
    mag   = {field, b_n_r[25:3]} + {30'd0, inc};
    if (b_spec_r) begin
      res = b_spv_r;
    end else if (b_zero_r) begin
      res = {b_zs_r, 31'd0};
    end else if (ovf) begin
      res = {b_sx_r, EXP_MAX, 23'd0};
    end else begin
      res = {b_sx_r, mag};
    end
  end

  logic        c_vld_r;
  logic [31:0] c_res_r, c_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (en) begin
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_res_r  <= res;
      c_side_r <= b_side_r;
    end
  end

  assign out_vld  = c_vld_r;
  assign d        = c_res_r;
  assign side_out = c_side_r;

endmodule
